@@ src/multi_header_message_deframer_assert.svh @@
// Assertion macros shared by the deframer's checker.
`ifndef MULTI_HEADER_MESSAGE_DEFRAMER_ASSERT_SVH
`define MULTI_HEADER_MESSAGE_DEFRAMER_ASSERT_SVH

// Clocked check, disabled while reset is asserted.
`define MHD_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define MHD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/mhd_pkg.sv @@
package mhd_pkg;

    localparam int HEADER_BYTES = 4;
    localparam int NUM_TYPES    = 4;
    localparam int MAX_PAYLOAD  = 127;

    // Register map is fixed: four header words, then four payload lengths.
    localparam int TYPE_SLOTS = 4;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam int LEN_W      = 7;
    localparam int PCNT_W     = 7;

    // Result count runs 0..HEADER_BYTES; header position runs 0..HEADER_BYTES-1.
    localparam int CNT_W  = $clog2(HEADER_BYTES + 1);
    localparam int HIDX_W = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;

    typedef enum logic [2:0] {
        REG_HDR0 = 3'd0,
        REG_HDR1 = 3'd1,
        REG_HDR2 = 3'd2,
        REG_HDR3 = 3'd3,
        REG_LEN0 = 3'd4,
        REG_LEN1 = 3'd5,
        REG_LEN2 = 3'd6,
        REG_LEN3 = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        KIND_CONSOLE = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_EMPTY   = 2'd2,
        KIND_TRUNC   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [1:0]  msg_type;
        logic [7:0]  out_byte;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [TYPE_SLOTS-1:0][31:0]      header_word;
        logic [TYPE_SLOTS-1:0][LEN_W-1:0] payload_len;
    } t_cfg;

    // One processed transaction's worth of results, handed to the result buffer.
    typedef struct packed {
        logic                             valid;
        logic [CNT_W-1:0]                 count;
        t_result [HEADER_BYTES-1:0]       items;
    } t_load;

endpackage

@@ src/mhd_cfg_regs.sv @@
module mhd_cfg_regs
    import mhd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;

    assign w_idx = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_comb begin
        n_cfg = r_cfg;
        if (psel && penable && pwrite) begin
            case (w_idx)
                REG_HDR0: n_cfg.header_word[0] = pwdata;
                REG_HDR1: n_cfg.header_word[1] = pwdata;
                REG_HDR2: n_cfg.header_word[2] = pwdata;
                REG_HDR3: n_cfg.header_word[3] = pwdata;
                REG_LEN0: n_cfg.payload_len[0] = pwdata[LEN_W-1:0];
                REG_LEN1: n_cfg.payload_len[1] = pwdata[LEN_W-1:0];
                REG_LEN2: n_cfg.payload_len[2] = pwdata[LEN_W-1:0];
                REG_LEN3: n_cfg.payload_len[3] = pwdata[LEN_W-1:0];
                default:  n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_HDR0: prdata = r_cfg.header_word[0];
            REG_HDR1: prdata = r_cfg.header_word[1];
            REG_HDR2: prdata = r_cfg.header_word[2];
            REG_HDR3: prdata = r_cfg.header_word[3];
            REG_LEN0: prdata = {{(DATA_W-LEN_W){1'b0}}, r_cfg.payload_len[0]};
            REG_LEN1: prdata = {{(DATA_W-LEN_W){1'b0}}, r_cfg.payload_len[1]};
            REG_LEN2: prdata = {{(DATA_W-LEN_W){1'b0}}, r_cfg.payload_len[2]};
            REG_LEN3: prdata = {{(DATA_W-LEN_W){1'b0}}, r_cfg.payload_len[3]};
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ src/mhd_core.sv @@
module mhd_core
    import mhd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_opcode,
    input  logic [7:0] i_rx_byte,
    input  logic       i_can_load,
    output t_load      o_load
);

    // Input register
    logic        r_in_valid;
    logic        r_in_opcode;
    logic [7:0]  r_in_byte;

    // Deframer state
    logic                  r_in_payload, n_in_payload;
    logic [HIDX_W-1:0]     r_hcnt,       n_hcnt;
    logic [TYPE_SLOTS-1:0] r_mask,       n_mask;
    logic [1:0]            r_chosen,     n_chosen;
    logic [PCNT_W-1:0]     r_pcnt,       n_pcnt;
    logic [7:0]            r_store [HEADER_BYTES];
    logic [7:0]            n_store [HEADER_BYTES];

    logic        w_move;
    logic        w_accept;
    logic        w_alive;
    logic [CNT_W-1:0] w_n;
    logic [7:0]  w_len;
    t_load       w_load;

    function automatic logic [7:0] hdr_byte(input logic [31:0] word, input int pos);
        logic [7:0] b;
        b = '0;
        if (pos < 4) begin
            b = word[8*pos +: 8];
        end
        return b;
    endfunction

    function automatic logic [7:0] type_len(input logic [LEN_W-1:0] len);
        logic [7:0] l;
        l = 8'(len);
        if (l > 8'(MAX_PAYLOAD)) begin
            l = 8'(MAX_PAYLOAD);
        end
        return l;
    endfunction

    assign w_move     = r_in_valid && i_can_load;
    assign o_in_stall = r_in_valid && !i_can_load;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_payload = r_in_payload;
        n_hcnt       = r_hcnt;
        n_mask       = r_mask;
        n_chosen     = r_chosen;
        n_pcnt       = r_pcnt;
        n_store      = r_store;
        w_alive      = 1'b0;
        w_n          = '0;
        w_len        = '0;
        w_load       = '0;

        if (w_move) begin
            w_load.valid = 1'b1;
            if (r_in_payload) begin
                w_load.count             = CNT_W'(1);
                w_load.items[0].msg_type = r_chosen;
                w_load.items[0].last     = 1'b1;
                if (r_in_opcode) begin
                    w_load.items[0].kind = KIND_TRUNC;
                    n_in_payload = 1'b0;
                    n_pcnt       = '0;
                end else begin
                    w_len = type_len(i_cfg.payload_len[r_chosen]);
                    w_load.items[0].kind     = KIND_PAYLOAD;
                    w_load.items[0].out_byte = r_in_byte;
                    if (8'(r_pcnt) + 8'd1 >= w_len) begin
                        n_in_payload = 1'b0;
                        n_pcnt       = '0;
                    end else begin
                        w_load.items[0].last = 1'b0;
                        n_pcnt = r_pcnt + PCNT_W'(1);
                    end
                end
            end else begin
                if (r_in_opcode) begin
                    // Timeout mid-header: flush what has been gathered.
                    w_n = CNT_W'(r_hcnt);
                end else begin
                    n_store[r_hcnt] = r_in_byte;
                    for (int t = 0; t < TYPE_SLOTS; t++) begin
                        if (t < NUM_TYPES && r_mask[t]) begin
                            if (hdr_byte(i_cfg.header_word[t], int'(r_hcnt)) != r_in_byte) begin
                                n_mask[t] = 1'b0;
                            end else begin
                                w_alive = 1'b1;
                            end
                        end
                    end
                    if (w_alive) begin
                        if (int'(r_hcnt) + 1 < HEADER_BYTES) begin
                            n_hcnt = r_hcnt + HIDX_W'(1);
                        end else begin
                            // Full match: lowest surviving type wins.
                            n_chosen = 2'd3;
                            for (int t = 2; t >= 0; t--) begin
                                if (n_mask[t]) begin
                                    n_chosen = 2'(t);
                                end
                            end
                            n_hcnt = '0;
                            n_mask = '1;
                            n_pcnt = '0;
                            if (type_len(i_cfg.payload_len[n_chosen]) == 8'd0) begin
                                w_load.count             = CNT_W'(1);
                                w_load.items[0].kind     = KIND_EMPTY;
                                w_load.items[0].msg_type = n_chosen;
                                w_load.items[0].last     = 1'b1;
                            end else begin
                                n_in_payload = 1'b1;
                            end
                        end
                    end else begin
                        w_n = CNT_W'(r_hcnt) + CNT_W'(1);
                    end
                end
                // Flush run (empty when the timeout found no header bytes).
                if (r_in_opcode || !w_alive) begin
                    w_load.count = w_n;
                    for (int i = 0; i < HEADER_BYTES; i++) begin
                        if (CNT_W'(i) < w_n) begin
                            w_load.items[i].kind     = KIND_CONSOLE;
                            w_load.items[i].out_byte = n_store[i];
                            w_load.items[i].last     = (CNT_W'(i + 1) == w_n);
                        end
                    end
                    n_hcnt = '0;
                    n_mask = '1;
                    n_pcnt = '0;
                end
            end
        end
    end

    assign o_load = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_in_payload <= 1'b0;
            r_hcnt       <= '0;
            r_mask       <= '1;
            r_chosen     <= '0;
            r_pcnt       <= '0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_move) begin
                r_in_valid <= 1'b0;
            end
            r_in_payload <= n_in_payload;
            r_hcnt       <= n_hcnt;
            r_mask       <= n_mask;
            r_chosen     <= n_chosen;
            r_pcnt       <= n_pcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_opcode <= i_opcode;
            r_in_byte   <= i_rx_byte;
        end
        r_store <= n_store;
    end

endmodule

@@ src/mhd_res_buf.sv @@
module mhd_res_buf
    import mhd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_load   i_load,
    output logic    o_can_load,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_result
);

    t_result [HEADER_BYTES-1:0] r_items, n_items;
    logic    [CNT_W-1:0]        r_cnt,   n_cnt;
    logic                       w_take;

    assign o_out_valid = (r_cnt != '0);
    assign w_take      = o_out_valid && !i_out_stall;
    assign o_can_load  = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && w_take);
    assign o_result    = r_items[0];

    always_comb begin
        n_items = r_items;
        n_cnt   = r_cnt;
        if (i_load.valid) begin
            n_items = i_load.items;
            n_cnt   = i_load.count;
        end else if (w_take) begin
            // Shift toward the output slot.
            for (int i = 0; i < HEADER_BYTES - 1; i++) begin
                n_items[i] = r_items[i + 1];
            end
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_items <= n_items;
    end

endmodule

@@ src/multi_header_message_deframer.sv @@
// Multi-header message deframer. Watches received serial bytes (opcode 0)
// and receive-timeout events (opcode 1), matches the byte stream against
// four programmable 4-byte headers at once, and on a full match hands out
// the configured number of payload bytes tagged with the message type.
// Bytes that turn out not to be a header are returned as console bytes,
// the offending byte included, with last set on the final one of the run.
// A zero-length type gives a single "empty message" result; a timeout in
// the middle of a payload gives a single "truncated" result. Throughput is
// one transaction per clock while each transaction yields at most one
// result and the output is not stalled; a header flush of k bytes queues
// k results for the single result port, and the next input transaction
// waits in the input register until the last of them is taken. Each input
// passes the input register, then the result buffer, on its way out.
// Program the header words and payload lengths over the APB port only
// while the block is idle; there is no clearing pass after reset.
module multi_header_message_deframer
    import mhd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,

    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,

    // Input transactions
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_opcode,
    input  logic [7:0]        i_rx_byte,

    // Result transactions
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_kind,
    output logic [1:0]        o_msg_type,
    output logic [7:0]        o_out_byte,
    output logic              o_last
);

    t_cfg    w_cfg;
    t_load   w_load;
    logic    w_can_load;
    t_result w_result;

    // Zero-wait-state register file.
    assign pready = 1'b1;

    mhd_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (w_cfg)
    );

    // Hold the transaction, match it against the headers, emit its results.
    mhd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_opcode   (i_opcode),
        .i_rx_byte  (i_rx_byte),
        .i_can_load (w_can_load),
        .o_load     (w_load)
    );

    // Drain results one per cycle to the output while it is not stalled.
    mhd_res_buf u_res_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .o_can_load  (w_can_load),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (w_result)
    );

    assign o_kind     = w_result.kind;
    assign o_msg_type = w_result.msg_type;
    assign o_out_byte = w_result.out_byte;
    assign o_last     = w_result.last;

endmodule

@@ src/mhd_checker.sv @@
`include "multi_header_message_deframer_assert.svh"

module mhd_checker
    import mhd_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_kind,
    input logic [1:0] o_msg_type,
    input logic [7:0] o_out_byte,
    input logic       o_last
);

    `MHD_ASSERT_RST(a_out_valid_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> o_out_valid, "result dropped while stalled")
    `MHD_ASSERT_RST(a_out_payload_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> ($stable(o_kind) && $stable(o_msg_type) && $stable(o_out_byte) && $stable(o_last)), "result changed while stalled")
    `MHD_ASSERT_ALWAYS(a_console_type_zero, i_clk, (o_out_valid && o_kind == KIND_CONSOLE) |-> (o_msg_type == 2'd0), "console byte carries a message type")
    `MHD_ASSERT_ALWAYS(a_marker_shape, i_clk, (o_out_valid && (o_kind == KIND_EMPTY || o_kind == KIND_TRUNC)) |-> (o_out_byte == 8'd0 && o_last), "completion or truncation result malformed")

endmodule

bind multi_header_message_deframer mhd_checker u_mhd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_kind      (o_kind),
    .o_msg_type  (o_msg_type),
    .o_out_byte  (o_out_byte),
    .o_last      (o_last)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import mhd_pkg::*;

    // Input opcodes: a received byte or an elapsed receive timeout.
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    localparam int RANDOM_ITEMS  = 165;    // random input transactions to send
    localparam int CALM_ITEMS    = 50;     // tail of the random part with no idling
    localparam int PHASE_ITEMS   = 55;     // input transactions per register setting
    localparam int SETTLE_CYCLES = 12;     // covers input register plus result buffer
    localparam int CYCLE_LIMIT   = 500000;

    // Clock, reset and DUT ports; every input starts at a known value.
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [DATA_W-1:0] pwdata      = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    logic              i_opcode    = OP_BYTE;
    logic [7:0]        i_rx_byte   = 8'h00;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [1:0]        o_kind;
    logic [1:0]        o_msg_type;
    logic [7:0]        o_out_byte;
    logic              o_last;

    multi_header_message_deframer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_rx_byte   (i_rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_kind      (o_kind),
        .o_msg_type  (o_msg_type),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Deframer mirror: register copies and hunt/collect state.
    // ------------------------------------------------------------------
    logic [31:0]      hdr_word [TYPE_SLOTS];
    logic [LEN_W-1:0] len_cfg  [TYPE_SLOTS];
    logic             collecting;          // set while payload bytes are due
    int               hdr_pos;             // header bytes matched so far
    logic [3:0]       alive_mask;          // types still matching the header
    logic [7:0]       hdr_seen [HEADER_BYTES];
    logic [1:0]       msg_sel;             // type whose payload is collected
    int               bytes_taken;         // payload bytes already passed on

    t_result pending_results [$];          // results still owed by the DUT

    int  items_sent  = 0;
    int  fail_count  = 0;
    int  cycle_count = 0;
    bit  gaps_on     = 1'b1;               // allow idle bursts on the input side
    bit  stall_on    = 1'b1;               // allow stall bursts on the result side
    int  stall_left  = 0;

    function automatic void push_result(input t_kind k, input logic [1:0] ty,
                                        input logic [7:0] b, input logic l);
        t_result r;
        r.kind     = k;
        r.msg_type = ty;
        r.out_byte = b;
        r.last     = l;
        pending_results.push_back(r);
    endfunction

    function automatic void restart_hunt();
        collecting  = 1'b0;
        hdr_pos     = 0;
        alive_mask  = 4'hF;
        bytes_taken = 0;
    endfunction

    // Return the partial header as console bytes, last flagged on the final one.
    function automatic void flush_header(input int n);
        for (int i = 0; i < n; i++) begin
            push_result(KIND_CONSOLE, 2'd0, hdr_seen[i], (i + 1 == n));
        end
        restart_hunt();
    endfunction

    function automatic int type_len(input logic [1:0] ty);
        int len;
        len = int'(len_cfg[ty]);
        if (len > MAX_PAYLOAD) begin
            len = MAX_PAYLOAD;
        end
        return len;
    endfunction

    // Advance the mirror by one accepted transaction and queue what it yields.
    function automatic void predict_deframe(input logic op, input logic [7:0] b);
        int   pos;
        int   t;
        int   len;
        logic any_alive;
        if (collecting) begin
            if (op == OP_TIMEOUT) begin
                push_result(KIND_TRUNC, msg_sel, 8'h00, 1'b1);
                restart_hunt();
            end else if (bytes_taken + 1 >= type_len(msg_sel)) begin
                push_result(KIND_PAYLOAD, msg_sel, b, 1'b1);
                restart_hunt();
            end else begin
                push_result(KIND_PAYLOAD, msg_sel, b, 1'b0);
                bytes_taken++;
            end
        end else if (op == OP_TIMEOUT) begin
            flush_header(hdr_pos);
        end else begin
            pos = hdr_pos;
            hdr_seen[pos] = b;
            any_alive = 1'b0;
            for (t = 0; t < NUM_TYPES; t++) begin
                if (alive_mask[t]) begin
                    if (hdr_word[t][8*pos +: 8] != b) begin
                        alive_mask[t] = 1'b0;
                    end else begin
                        any_alive = 1'b1;
                    end
                end
            end
            pos++;
            if (!any_alive) begin
                flush_header(pos);
            end else if (pos < HEADER_BYTES) begin
                hdr_pos = pos;
            end else begin
                // Lowest surviving type wins; type 3 when none of 0..2 survived.
                msg_sel = 2'd3;
                for (t = 2; t >= 0; t--) begin
                    if (alive_mask[t]) begin
                        msg_sel = t[1:0];
                    end
                end
                len = type_len(msg_sel);
                restart_hunt();
                if (len == 0) begin
                    push_result(KIND_EMPTY, msg_sel, 8'h00, 1'b1);
                end else begin
                    collecting = 1'b1;
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall bursts, then compare every transaction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (stall_on && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 18);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    t_result want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                if (fail_count < 10) begin
                    $display("unexpected result: kind=%0d type=%0d byte=%02h last=%0b",
                             o_kind, o_msg_type, o_out_byte, o_last);
                end
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_kind !== want.kind || o_msg_type !== want.msg_type ||
                    o_out_byte !== want.out_byte || o_last !== want.last) begin
                    if (fail_count < 10) begin
                        $write("result mismatch: expected kind=%0d type=%0d byte=%02h ",
                               want.kind, want.msg_type, want.out_byte);
                        $display("last=%0b, got kind=%0d type=%0d byte=%02h last=%0b",
                                 want.last, o_kind, o_msg_type, o_out_byte, o_last);
                    end
                    fail_count++;
                end
            end
        end
    end

    // Hard stop in case the DUT hangs or loses results.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Present one input transaction and hold it until accepted. Valid stays
    // high afterwards so back-to-back transactions need no idle gap between them;
    // drop it only ahead of an idle burst or in drain_results.
    task automatic send_item(input logic op, input logic [7:0] b);
        int gap;
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_deframe(op, b);
        items_sent++;
    endtask

    // Drop valid, wait for every owed result, then let in-flight work settle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, access cycle, write lands with pready high.
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_HDR0, REG_HDR1, REG_HDR2, REG_HDR3: hdr_word[idx[1:0]] = val;
            default: len_cfg[idx[1:0]] = val[LEN_W-1:0];
        endcase
    endtask

    // Length register word with junk in the unused upper bits.
    function automatic logic [31:0] len_word(input logic [LEN_W-1:0] len);
        logic [31:0] r;
        r = $urandom();
        return {r[31:LEN_W], len};
    endfunction

    task automatic load_config(input logic [31:0] h0, h1, h2, h3,
                               input logic [LEN_W-1:0] l0, l1, l2, l3);
        write_reg(REG_HDR0, h0);
        write_reg(REG_HDR1, h1);
        write_reg(REG_HDR2, h2);
        write_reg(REG_HDR3, h3);
        write_reg(REG_LEN0, len_word(l0));
        write_reg(REG_LEN1, len_word(l1));
        write_reg(REG_LEN2, len_word(l2));
        write_reg(REG_LEN3, len_word(l3));
    endtask

    task automatic send_header(input int ty);
        for (int i = 0; i < HEADER_BYTES; i++) begin
            send_item(OP_BYTE, hdr_word[ty][8*i +: 8]);
        end
    endtask

    // Mostly short payloads, with empty and maximum lengths mixed in.
    function automatic logic [LEN_W-1:0] pick_len();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return LEN_W'(MAX_PAYLOAD);
        end
        return LEN_W'($urandom_range(1, 6));
    endfunction

    // One random frame: mostly well-formed messages with random payload,
    // the rest broken headers, timeouts and line noise.
    task automatic send_random_frame();
        int          sel;
        int          ty;
        int          p;
        logic [7:0]  b;
        sel = $urandom_range(0, 9);
        ty  = $urandom_range(0, TYPE_SLOTS - 1);
        case (sel)
            0, 1, 2, 3, 4, 5: begin
                send_header(ty);
                // Feed payload until the message closes; cut some short.
                while (collecting) begin
                    if ($urandom_range(0, 24) == 0) begin
                        send_item(OP_TIMEOUT, 8'($urandom()));
                    end else begin
                        send_item(OP_BYTE, 8'($urandom()));
                    end
                end
            end
            6: begin
                // Corrupt one header position so the match breaks there.
                p = $urandom_range(0, HEADER_BYTES - 1);
                for (int i = 0; i <= p; i++) begin
                    b = hdr_word[ty][8*i +: 8];
                    if (i == p) begin
                        b = b ^ 8'($urandom_range(1, 255));
                    end
                    send_item(OP_BYTE, b);
                end
            end
            7: begin
                p = $urandom_range(1, HEADER_BYTES - 1);
                for (int i = 0; i < p; i++) begin
                    send_item(OP_BYTE, hdr_word[ty][8*i +: 8]);
                end
                send_item(OP_TIMEOUT, 8'($urandom()));
            end
            8: send_item(OP_TIMEOUT, 8'($urandom()));
            default: begin
                p = $urandom_range(1, 4);
                repeat (p) send_item(OP_BYTE, 8'($urandom()));
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset leaves all headers zero and all lengths zero: four zero bytes
    // form an empty type 0 message; a timeout with no header is silent.
    task automatic test_reset_state();
        repeat (HEADER_BYTES) send_item(OP_BYTE, 8'h00);
        send_item(OP_TIMEOUT, 8'hFF);
    endtask

    // Full matches, a shared prefix split at the last byte, a four-byte
    // flush, a flush on timeout, and a payload cut by a timeout.
    task automatic test_header_matching();
        drain_results();
        load_config(32'h0000_0000, 32'hFFFF_FFFF, 32'h3CC3_5AA5, 32'h96C3_5AA5,
                    '0, LEN_W'(MAX_PAYLOAD), LEN_W'(2), LEN_W'(1));
        send_header(2);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        send_header(3);
        send_item(OP_BYTE, 8'h80);
        send_item(OP_BYTE, 8'hA5);
        send_item(OP_BYTE, 8'h5A);
        send_item(OP_BYTE, 8'hC3);
        send_item(OP_BYTE, 8'h11);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_TIMEOUT, 8'h00);
        send_header(2);
        send_item(OP_TIMEOUT, 8'h5A);
    endtask

    // Shrink the length of the type being collected: the next byte is final
    // because the running count already reaches the new length.
    task automatic test_length_rewrite();
        drain_results();
        write_reg(REG_LEN2, len_word(LEN_W'(10)));
        send_header(2);
        send_item(OP_BYTE, 8'h01);
        send_item(OP_BYTE, 8'h02);
        drain_results();
        write_reg(REG_LEN2, len_word(LEN_W'(2)));
        send_item(OP_BYTE, 8'h03);
    endtask

    // One message of the maximum payload length.
    task automatic test_long_payload();
        send_header(1);
        repeat (MAX_PAYLOAD) send_item(OP_BYTE, 8'($urandom()));
    endtask

    // Configuration phases with random, extreme, duplicated and
    // prefix-sharing headers; the tail runs without idling.
    task automatic test_random_traffic();
        logic [31:0] h [TYPE_SLOTS];
        int          target;
        int          phase;
        int          phase_start;
        target = items_sent + RANDOM_ITEMS;
        phase  = 0;
        while (items_sent < target) begin
            drain_results();
            for (int i = 0; i < TYPE_SLOTS; i++) begin
                h[i] = $urandom();
            end
            case (phase % 4)
                1: begin
                    h[0] = 32'h0000_0000;
                    h[1] = 32'hFFFF_FFFF;
                end
                2: begin
                    h[1] = h[0];
                    h[3] = {h[2][31:24] ^ 8'($urandom_range(1, 255)), h[2][23:0]};
                end
                3: begin
                    h[1][7:0]  = h[0][7:0];
                    h[2][15:0] = h[0][15:0];
                end
                default: ;
            endcase
            load_config(h[0], h[1], h[2], h[3], pick_len(), pick_len(), pick_len(),
                        pick_len());
            gaps_on     = ($urandom_range(0, 3) != 0);
            stall_on    = ($urandom_range(0, 3) != 0);
            phase_start = items_sent;
            while (items_sent < target && items_sent - phase_start < PHASE_ITEMS) begin
                if (target - items_sent <= CALM_ITEMS) begin
                    gaps_on  = 1'b0;
                    stall_on = 1'b0;
                end
                send_random_frame();
            end
            phase++;
        end
    endtask

    initial begin
        hdr_word = '{default: '0};
        len_cfg  = '{default: '0};
        hdr_seen = '{default: '0};
        msg_sel  = 2'd0;
        restart_hunt();

        // Hold reset at the start, once.
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_header_matching();
        test_length_rewrite();
        test_long_payload();
        test_random_traffic();

        drain_results();
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/mhd_pkg.sv
src/mhd_cfg_regs.sv
src/mhd_core.sv
src/mhd_res_buf.sv
src/multi_header_message_deframer.sv
src/mhd_checker.sv
tb/testbench.sv
